@@ hw/rtl/handle_table_allocator_top_defines.svh @@
// ---------------------------------------------------------------------------
// Handle table allocator: assertion macros
// Concurrent assertion wrappers, compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef HANDLE_TABLE_ALLOCATOR_TOP_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define HTA_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);
// Checked at every edge, reset included.
`define HTA_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) \
        else $error(msg);
`else
`define HTA_ASSERT_RST(label, prop, msg)
`define HTA_ASSERT_ANY(label, prop, msg)
`endif

`endif

@@ hw/rtl/hta_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hta_pkg
// Shared widths, codes and types of the handle table allocator.
// ---------------------------------------------------------------------------
package hta_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int FIRST_FREE  = 3;

    localparam int REQ_W      = 3;
    localparam int HANDLE_W   = 8;
    localparam int VOL_W      = 16;
    localparam int INODE_W    = 64;
    localparam int FLAGS_W    = 16;
    localparam int STATUS_W   = 3;

    localparam int IN_DATA_W    = 2 * HANDLE_W + VOL_W + INODE_W + 2 * FLAGS_W;
    localparam int OUT_FIELDS_W = 1 + STATUS_W + HANDLE_W + VOL_W + INODE_W + 2 * FLAGS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam logic [FLAGS_W-1:0] FLAGS_READ_ONLY  = FLAGS_W'(0);
    localparam logic [FLAGS_W-1:0] FLAGS_WRITE_ONLY = FLAGS_W'(1);

    // free-handle scan: one group of valid bits per cycle
    localparam int SCAN_W     = 8;
    localparam int LSB_W      = $clog2(SCAN_W);
    localparam int NUM_GROUPS = (TABLE_DEPTH + SCAN_W - 1) / SCAN_W;
    localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
    localparam int SPAN       = NUM_GROUPS * SCAN_W;
    localparam int INIT_CNT_W = $clog2(FIRST_FREE);

    typedef enum logic [REQ_W-1:0] {
        REQ_INIT      = 3'd0,
        REQ_ALLOC     = 3'd1,
        REQ_FREE      = 3'd2,
        REQ_DUP       = 3'd3,
        REQ_DUP2      = 3'd4,
        REQ_LOOKUP    = 3'd5,
        REQ_SET_FLAGS = 3'd6
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NOT_INIT = 3'd1,
        ST_RANGE    = 3'd2,
        ST_NOT_OPEN = 3'd3,
        ST_FULL     = 3'd4,
        ST_RESERVED = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_INIT,
        S_SCAN,
        S_COPY,
        S_LOOKUP,
        S_SETFL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [VOL_W-1:0]   vol;
        logic [INODE_W-1:0] inode;
        logic [FLAGS_W-1:0] open_flags;
        logic [FLAGS_W-1:0] desc_flags;
    } entry_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } ram_wr_t;

endpackage
`default_nettype wire

@@ hw/rtl/hta_entry_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hta_entry_ram
// Entry payload store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module hta_entry_ram (
    input  logic                      aclk,
    input  hta_pkg::ram_wr_t          wr,
    input  logic                      rd_en,
    input  logic [hta_pkg::IDX_W-1:0] rd_addr,
    output hta_pkg::entry_t           rd_data
);
    import hta_pkg::*;

    entry_t mem [TABLE_DEPTH];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

@@ hw/rtl/handle_table_allocator_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// handle_table_allocator_top
// Lowest-free handle table: init, alloc, free, dup, dup2, lookup, set flags.
// ---------------------------------------------------------------------------
// One request beat in, one result beat out; the block takes a request only
// when idle and holds the result until it is taken. Valid bits live in
// flops, entry payloads in a RAM with one write port and one registered read
// port. Free, init of a ready table, dup2 onto itself and any refused
// request finish in the execute step; lookup, set flags and dup2 take one
// RAM read, then a write or a capture; init writes the three reserved
// entries one per cycle; alloc and dup walk the free-handle scan over the
// 8-bit groups of valid bits, 1 to NUM_GROUPS (8 for 64 entries) of them,
// until a hit or a full table. Every request then waits in the result
// state until its beat is taken, and goes back to idle.
// ---------------------------------------------------------------------------
`include "handle_table_allocator_top_defines.svh"

module handle_table_allocator_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // handle, target_handle, volume_tag, inode, open_flags, desc_flags_value
    input  logic [hta_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type
    input  logic [hta_pkg::REQ_W-1:0]      s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // ok, status, result_handle, out_volume_tag, out_inode, out_open_flags,
    // out_desc_flags, zero pad
    output logic [hta_pkg::OUT_DATA_W-1:0] m_tdata
);
    import hta_pkg::*;

    localparam int T_LO   = HANDLE_W;
    localparam int VOL_LO = 2 * HANDLE_W;
    localparam int INO_LO = VOL_LO + VOL_W;
    localparam int OFL_LO = INO_LO + INODE_W;
    localparam int DFL_LO = OFL_LO + FLAGS_W;

    typedef struct packed {
        logic [FLAGS_W-1:0]  desc_flags;
        logic [FLAGS_W-1:0]  open_flags;
        logic [INODE_W-1:0]  inode;
        logic [VOL_W-1:0]    vol;
        logic [HANDLE_W-1:0] handle;
        status_t             status;
    } res_t;

    state_t                  state_reg, state_next;
    logic                    ready_reg, ready_next;
    logic [TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic [GRP_W-1:0]        grp_reg, grp_next;
    logic [INIT_CNT_W-1:0]   init_cnt_reg, init_cnt_next;
    res_t                    res_reg, res_next;

    req_t                    req_reg;
    logic [HANDLE_W-1:0]     h_reg, t_reg;
    logic [VOL_W-1:0]        vol_reg;
    logic [INODE_W-1:0]      ino_reg;
    logic [FLAGS_W-1:0]      ofl_reg, dfl_reg;

    ram_wr_t                 ram_wr;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    entry_t                  rd_data;

    logic                    h_oob, t_oob, h_open;
    logic [IDX_W-1:0]        h_idx, t_idx;
    logic [SPAN-1:0]         valid_span;
    logic [SCAN_W-1:0]       grp_bits;
    logic                    grp_hit, grp_last;
    logic [LSB_W-1:0]        hit_lsb;
    logic [IDX_W-1:0]        scan_idx;
    logic                    s_beat;

    assign s_beat = s_tvalid && s_tready;

    // request capture
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            req_reg <= req_t'(s_tuser);
            h_reg   <= s_tdata[HANDLE_W-1:0];
            t_reg   <= s_tdata[T_LO +: HANDLE_W];
            vol_reg <= s_tdata[VOL_LO +: VOL_W];
            ino_reg <= s_tdata[INO_LO +: INODE_W];
            ofl_reg <= s_tdata[OFL_LO +: FLAGS_W];
            dfl_reg <= s_tdata[DFL_LO +: FLAGS_W];
        end
    end

    assign h_oob  = {1'b0, h_reg} >= (HANDLE_W + 1)'(TABLE_DEPTH);
    assign t_oob  = {1'b0, t_reg} >= (HANDLE_W + 1)'(TABLE_DEPTH);
    assign h_idx  = h_reg[IDX_W-1:0];
    assign t_idx  = t_reg[IDX_W-1:0];
    assign h_open = valid_reg[h_idx];

    // reserved handles and padding past the table read as taken
    always_comb begin
        for (int i = 0; i < SPAN; i++) begin
            if (i < TABLE_DEPTH) begin
                valid_span[i] = valid_reg[i] || (i < FIRST_FREE);
            end else begin
                valid_span[i] = 1'b1;
            end
        end
    end

    assign grp_bits = valid_span[grp_reg * SCAN_W +: SCAN_W];
    assign grp_hit  = ~&grp_bits;
    assign grp_last = (grp_reg == GRP_W'(NUM_GROUPS - 1));

    always_comb begin
        hit_lsb = '0;
        for (int i = SCAN_W - 1; i >= 0; i--) begin
            if (!grp_bits[i]) begin
                hit_lsb = LSB_W'(i);
            end
        end
    end

    assign scan_idx = IDX_W'({grp_reg, hit_lsb});

    hta_entry_ram u_ram (
        .aclk    (aclk),
        .wr      (ram_wr),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            ready_reg    <= 1'b0;
            valid_reg    <= '0;
            grp_reg      <= '0;
            init_cnt_reg <= '0;
        end else begin
            state_reg    <= state_next;
            ready_reg    <= ready_next;
            valid_reg    <= valid_next;
            grp_reg      <= grp_next;
            init_cnt_reg <= init_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_comb begin
        state_next    = state_reg;
        ready_next    = ready_reg;
        valid_next    = valid_reg;
        grp_next      = grp_reg;
        init_cnt_next = init_cnt_reg;
        res_next      = res_reg;
        ram_wr        = '0;
        rd_en         = 1'b0;
        rd_addr       = h_idx;
        s_tready      = (state_reg == S_IDLE);
        m_tvalid      = (state_reg == S_OUT);

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_next        = '0;
                res_next.status = ST_OK;
                state_next      = S_OUT;
                case (req_reg)
                    REQ_INIT: begin
                        if (!ready_reg) begin
                            valid_next    = '0;
                            init_cnt_next = '0;
                            state_next    = S_INIT;
                        end
                    end
                    REQ_ALLOC: begin
                        if (!ready_reg) begin
                            res_next.status = ST_NOT_INIT;
                        end else begin
                            grp_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    REQ_FREE: begin
                        res_next.handle = h_reg;
                        if (h_oob) begin
                            res_next.status = ST_RANGE;
                        end else if (!h_open) begin
                            res_next.status = ST_NOT_OPEN;
                        end else if (h_idx < IDX_W'(FIRST_FREE)) begin
                            res_next.status = ST_RESERVED;
                        end else begin
                            valid_next[h_idx] = 1'b0;
                        end
                    end
                    REQ_DUP: begin
                        if (h_oob) begin
                            res_next.status = ST_RANGE;
                        end else if (!h_open) begin
                            res_next.status = ST_NOT_OPEN;
                        end else if (!ready_reg) begin
                            res_next.status = ST_NOT_INIT;
                        end else begin
                            rd_en      = 1'b1;
                            grp_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    REQ_DUP2: begin
                        res_next.handle = t_reg;
                        if (t_oob || h_oob) begin
                            res_next.status = ST_RANGE;
                        end else if (!h_open) begin
                            res_next.status = ST_NOT_OPEN;
                        end else if (h_reg != t_reg) begin
                            rd_en      = 1'b1;
                            state_next = S_COPY;
                        end
                    end
                    REQ_LOOKUP, REQ_SET_FLAGS: begin
                        res_next.handle = h_reg;
                        if (h_oob) begin
                            res_next.status = ST_RANGE;
                        end else if (!h_open) begin
                            res_next.status = ST_NOT_OPEN;
                        end else begin
                            rd_en      = 1'b1;
                            state_next = (req_reg == REQ_LOOKUP) ? S_LOOKUP : S_SETFL;
                        end
                    end
                    default: begin
                        res_next.status = ST_RANGE;
                    end
                endcase
            end
            S_INIT: begin
                ram_wr.en              = 1'b1;
                ram_wr.addr            = IDX_W'(init_cnt_reg);
                ram_wr.data.open_flags = (init_cnt_reg == '0) ? FLAGS_READ_ONLY
                                                              : FLAGS_WRITE_ONLY;
                valid_next[IDX_W'(init_cnt_reg)] = 1'b1;
                if (init_cnt_reg == INIT_CNT_W'(FIRST_FREE - 1)) begin
                    ready_next = 1'b1;
                    state_next = S_OUT;
                end else begin
                    init_cnt_next = init_cnt_reg + 1'b1;
                end
            end
            S_SCAN: begin
                if (grp_hit) begin
                    ram_wr.en   = 1'b1;
                    ram_wr.addr = scan_idx;
                    if (req_reg == REQ_DUP) begin
                        ram_wr.data.vol        = rd_data.vol;
                        ram_wr.data.inode      = rd_data.inode;
                        ram_wr.data.open_flags = rd_data.open_flags;
                    end else begin
                        ram_wr.data.vol        = vol_reg;
                        ram_wr.data.inode      = ino_reg;
                        ram_wr.data.open_flags = ofl_reg;
                    end
                    valid_next[scan_idx] = 1'b1;
                    res_next.handle      = HANDLE_W'(scan_idx);
                    state_next           = S_OUT;
                end else if (grp_last) begin
                    res_next.status = ST_FULL;
                    state_next      = S_OUT;
                end else begin
                    grp_next = grp_reg + 1'b1;
                end
            end
            S_COPY: begin
                ram_wr.en         = 1'b1;
                ram_wr.addr       = t_idx;
                ram_wr.data       = rd_data;
                valid_next[t_idx] = 1'b1;
                state_next        = S_OUT;
            end
            S_LOOKUP: begin
                res_next.vol        = rd_data.vol;
                res_next.inode      = rd_data.inode;
                res_next.open_flags = rd_data.open_flags;
                res_next.desc_flags = rd_data.desc_flags;
                state_next          = S_OUT;
            end
            S_SETFL: begin
                ram_wr.en              = 1'b1;
                ram_wr.addr            = h_idx;
                ram_wr.data            = rd_data;
                ram_wr.data.desc_flags = dfl_reg;
                state_next             = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tdata = OUT_DATA_W'({res_reg, (res_reg.status == ST_OK)});

    `HTA_ASSERT_RST(a_one_side_open, !(s_tready && m_tvalid),
        "input and result open together")
    `HTA_ASSERT_RST(a_busy_after_beat, s_beat |=> !s_tready,
        "request taken while busy")
    `HTA_ASSERT_RST(a_ready_sticky, ready_reg |=> ready_reg,
        "table ready dropped")
    `HTA_ASSERT_RST(a_reserved_kept, ready_reg |-> (&valid_reg[FIRST_FREE-1:0]),
        "reserved handle lost")
    `HTA_ASSERT_RST(a_scan_above_reserved,
        (ram_wr.en && (state_reg == S_SCAN)) |-> (ram_wr.addr >= IDX_W'(FIRST_FREE)),
        "scan wrote a reserved handle")

endmodule
`default_nettype wire

@@ dv/tb_handle_table_allocator_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_handle_table_allocator_top
// Drives handle table requests (init, alloc, free, dup, dup2, lookup, set
// flags, plus the undefined code) into the block, tracks a shadow copy of
// the table and compares every result beat field by field, in order.
// ---------------------------------------------------------------------------
module tb_handle_table_allocator_top;
    import hta_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNDEFINED = 3'd7;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 1950;
    localparam int GROUP_LEN    = 50;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    // result beat, lowest field last so it lines up with m_tdata
    typedef struct packed {
        logic [FLAGS_W-1:0]  desc_flags;
        logic [FLAGS_W-1:0]  open_flags;
        logic [INODE_W-1:0]  inode;
        logic [VOL_W-1:0]    vol;
        logic [HANDLE_W-1:0] handle;
        status_t             status;
        logic                ok;
    } result_t;

    class handle_table_shadow;
        bit                  ready;
        bit                  valid[TABLE_DEPTH];
        logic [VOL_W-1:0]    vol[TABLE_DEPTH];
        logic [INODE_W-1:0]  inode[TABLE_DEPTH];
        logic [FLAGS_W-1:0]  oflags[TABLE_DEPTH];
        logic [FLAGS_W-1:0]  dflags[TABLE_DEPTH];
        result_t             expected_results[$];
        int                  errors;

        function void clear_entry(int idx);
            valid[idx]  = 1'b0;
            vol[idx]    = '0;
            inode[idx]  = '0;
            oflags[idx] = '0;
            dflags[idx] = '0;
        endfunction

        function new();
            ready  = 1'b0;
            errors = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) clear_entry(i);
        endfunction

        // lowest free handle above the reserved ones
        function status_t take_entry(logic [VOL_W-1:0] v, logic [INODE_W-1:0] ino,
                                     logic [FLAGS_W-1:0] fl,
                                     output logic [HANDLE_W-1:0] got);
            int slot;
            got = '0;
            if (!ready) return ST_NOT_INIT;
            slot = TABLE_DEPTH;
            for (int i = TABLE_DEPTH - 1; i >= FIRST_FREE; i--)
                if (!valid[i]) slot = i;
            if (slot >= TABLE_DEPTH) return ST_FULL;
            clear_entry(slot);
            valid[slot]  = 1'b1;
            vol[slot]    = v;
            inode[slot]  = ino;
            oflags[slot] = fl;
            got = HANDLE_W'(slot);
            return ST_OK;
        endfunction

        function void note_request(logic [REQ_W-1:0] req, logic [IN_DATA_W-1:0] d);
            logic [HANDLE_W-1:0] h, t, got;
            logic [VOL_W-1:0]    v;
            logic [INODE_W-1:0]  ino;
            logic [FLAGS_W-1:0]  ofl, dfl;
            result_t             r;
            {dfl, ofl, ino, v, t, h} = d;
            r = '0;
            r.status = ST_OK;
            case (req)
                REQ_INIT: begin
                    if (!ready) begin
                        for (int i = 0; i < TABLE_DEPTH; i++) clear_entry(i);
                        for (int i = 0; i < FIRST_FREE; i++) begin
                            valid[i]  = 1'b1;
                            oflags[i] = (i == 0) ? FLAGS_READ_ONLY : FLAGS_WRITE_ONLY;
                        end
                        ready = 1'b1;
                    end
                end
                REQ_ALLOC: begin
                    r.status = take_entry(v, ino, ofl, got);
                    r.handle = got;
                end
                REQ_FREE: begin
                    r.handle = h;
                    if (h >= TABLE_DEPTH)      r.status = ST_RANGE;
                    else if (!valid[h])        r.status = ST_NOT_OPEN;
                    else if (h < FIRST_FREE)   r.status = ST_RESERVED;
                    else                       clear_entry(h);
                end
                REQ_DUP: begin
                    if (h >= TABLE_DEPTH)      r.status = ST_RANGE;
                    else if (!valid[h])        r.status = ST_NOT_OPEN;
                    else begin
                        r.status = take_entry(vol[h], inode[h], oflags[h], got);
                        r.handle = got;
                    end
                end
                REQ_DUP2: begin
                    r.handle = t;
                    if (t >= TABLE_DEPTH || h >= TABLE_DEPTH) r.status = ST_RANGE;
                    else if (!valid[h])        r.status = ST_NOT_OPEN;
                    else if (h != t) begin
                        // reserved targets get overwritten too
                        valid[t]  = 1'b1;
                        vol[t]    = vol[h];
                        inode[t]  = inode[h];
                        oflags[t] = oflags[h];
                        dflags[t] = dflags[h];
                    end
                end
                REQ_LOOKUP, REQ_SET_FLAGS: begin
                    r.handle = h;
                    if (h >= TABLE_DEPTH)      r.status = ST_RANGE;
                    else if (!valid[h])        r.status = ST_NOT_OPEN;
                    else if (req == REQ_LOOKUP) begin
                        r.vol        = vol[h];
                        r.inode      = inode[h];
                        r.open_flags = oflags[h];
                        r.desc_flags = dflags[h];
                    end else begin
                        dflags[h] = dfl;
                    end
                end
                default: r.status = ST_RANGE;
            endcase
            r.ok = (r.status == ST_OK);
            expected_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [INODE_W-1:0] e,
                                    logic [INODE_W-1:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h",
                         $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            result_t act, e;
            act = result_t'(d[OUT_FIELDS_W-1:0]);
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result beat: expected none, actual 0x%0h",
                         $time, d);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            compare_field("ok",             e.ok,         act.ok);
            compare_field("status",         e.status,     act.status);
            compare_field("result_handle",  e.handle,     act.handle);
            compare_field("out_volume_tag", e.vol,        act.vol);
            compare_field("out_inode",      e.inode,      act.inode);
            compare_field("out_open_flags", e.open_flags, act.open_flags);
            compare_field("out_desc_flags", e.desc_flags, act.desc_flags);
        endfunction

        function int outstanding();
            return expected_results.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    handle_table_shadow shadow = new();
    int  cycle_count = 0;
    bit  no_gaps = 1'b0;
    bit  rx_hold_req = 1'b0;

    handle_table_allocator_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // results checked before the request of the same edge is noted
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) shadow.check_result(m_tdata);
            if (s_tvalid && s_tready) shadow.note_request(s_tuser, s_tdata);
        end
    end

    // mostly zero, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_req(
        logic [HANDLE_W-1:0] h, logic [HANDLE_W-1:0] t, logic [VOL_W-1:0] v,
        logic [INODE_W-1:0] ino, logic [FLAGS_W-1:0] ofl, logic [FLAGS_W-1:0] dfl);
        return {dfl, ofl, ino, v, t, h};
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)  return HANDLE_W'($urandom_range(0, FIRST_FREE - 1));
        if (r < 90) return HANDLE_W'($urandom_range(FIRST_FREE, TABLE_DEPTH - 1));
        return HANDLE_W'($urandom_range(TABLE_DEPTH, 255));
    endfunction

    function automatic logic [REQ_W-1:0] pick_req(int mode);
        int r;
        int lim[6];
        logic [REQ_W-1:0] kinds[6];
        kinds = '{REQ_ALLOC, REQ_DUP, REQ_FREE, REQ_DUP2, REQ_LOOKUP, REQ_SET_FLAGS};
        r = $urandom_range(0, 99);
        if (r < 2) return REQ_INIT;
        if (r < 4) return REQ_UNDEFINED;
        case (mode)
            MODE_FILL:  lim = '{55, 70, 78, 86, 93, 100};
            MODE_DRAIN: lim = '{10, 15, 70, 80, 92, 100};
            default:    lim = '{20, 30, 50, 65, 85, 100};
        endcase
        r = $urandom_range(0, 99);
        for (int i = 0; i < 6; i++)
            if (r < lim[i]) return kinds[i];
        return REQ_LOOKUP;
    endfunction

    // holds the beat until taken; valid only drops when a gap follows
    task automatic send_request(input logic [REQ_W-1:0] req,
                                input logic [IN_DATA_W-1:0] data);
        int gap;
        s_tuser  <= req;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = no_gaps ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (shadow.outstanding() != 0) @(posedge aclk);
    endtask

    // receiver: ready stretches, random stalls, one long hold on request
    initial begin
        int n;
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge aclk);
                n = idle_len();
                if (n > 0) begin
                    m_tready <= 1'b0;
                    repeat (n) @(posedge aclk);
                end
            end
        end
    end

    initial begin
        logic [HANDLE_W-1:0] h, t;
        logic [INODE_W-1:0]  ones;
        int mode;
        ones = '1;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= '0;
        s_tdata  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // before init: everything refused
        send_request(REQ_ALLOC,     pack_req(0, 0, 16'h1234, 64'h55, 16'h2, 0));
        send_request(REQ_DUP,       pack_req(0, 0, 0, 0, 0, 0));
        send_request(REQ_LOOKUP,    pack_req(0, 0, 0, 0, 0, 0));
        send_request(REQ_FREE,      pack_req(8'hff, 0, 0, 0, 0, 0));
        send_request(REQ_UNDEFINED, pack_req(8'hff, 8'hff, '1, ones, '1, '1));
        send_request(REQ_SET_FLAGS, pack_req(TABLE_DEPTH - 1, 0, 0, 0, 0, 16'h7));
        // init twice: second leaves the table alone
        send_request(REQ_INIT,      pack_req(0, 0, 0, 0, 0, 0));
        send_request(REQ_INIT,      pack_req(0, 0, 0, 0, 0, 0));
        send_request(REQ_LOOKUP,    pack_req(0, 0, 0, 0, 0, 0));
        send_request(REQ_LOOKUP,    pack_req(2, 0, 0, 0, 0, 0));
        send_request(REQ_FREE,      pack_req(1, 0, 0, 0, 0, 0));
        send_request(REQ_FREE,      pack_req(TABLE_DEPTH, 0, 0, 0, 0, 0));
        send_request(REQ_ALLOC,     pack_req(0, 0, '1, ones, '1, '1));
        send_request(REQ_ALLOC,     pack_req(0, 0, 0, 0, 0, 0));
        send_request(REQ_SET_FLAGS, pack_req(3, 0, 0, 0, 0, '1));
        send_request(REQ_DUP,       pack_req(3, 0, 0, 0, 0, 0));
        send_request(REQ_LOOKUP,    pack_req(5, 0, 0, 0, 0, 0));
        // dup2 over a reserved handle, onto itself, out of range both ways
        send_request(REQ_DUP2,      pack_req(3, 1, 0, 0, 0, 0));
        send_request(REQ_LOOKUP,    pack_req(1, 0, 0, 0, 0, 0));
        send_request(REQ_DUP2,      pack_req(3, 3, 0, 0, 0, 0));
        send_request(REQ_DUP2,      pack_req(8'hff, 4, 0, 0, 0, 0));
        send_request(REQ_DUP2,      pack_req(4, 8'hff, 0, 0, 0, 0));
        send_request(REQ_DUP2,      pack_req(40, 6, 0, 0, 0, 0));
        send_request(REQ_FREE,      pack_req(3, 0, 0, 0, 0, 0));
        send_request(REQ_FREE,      pack_req(3, 0, 0, 0, 0, 0));

        for (int g = 0; g < RANDOM_ITEMS / GROUP_LEN; g++) begin
            // first groups fill the table so the full case is reached early
            mode    = (g < 2) ? MODE_FILL : $urandom_range(MODE_FILL, MODE_MIX);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (g == 12) rx_hold_req = 1'b1;
            if (g == 25) wait_drained();
            for (int i = 0; i < GROUP_LEN; i++) begin
                h = pick_handle();
                t = ($urandom_range(0, 9) == 0) ? h : pick_handle();
                send_request(pick_req(mode),
                             pack_req(h, t, VOL_W'($urandom), {$urandom, $urandom},
                                      FLAGS_W'($urandom), FLAGS_W'($urandom)));
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (shadow.errors == 0 && shadow.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
